>>> sv/sbr_pkg.sv
// Package for the sonar burst ranger: constants, codes, microcode types and program.
`default_nettype none

package sbr_pkg;

  // Default build values for the top-level parameters.
  localparam int MAX_READINGS_DEF = 16;
  localparam int WIDTH_BITS_DEF   = 17;

  // Fixed widths of the configuration registers.
  localparam int RPB_W   = 5;
  localparam int TRIG_W  = 10;
  localparam int START_W = 16;
  localparam int WTO_W   = 17;
  localparam int SAFE_W  = 17;
  localparam int GAP_W   = 20;

  // Configuration port shape.
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_READINGS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_TMO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_TMO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_GAP    = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [RPB_W-1:0]   RST_READINGS   = 5'd4;
  localparam logic [TRIG_W-1:0]  RST_TRIG_WIDTH = 10'd10;
  localparam logic [START_W-1:0] RST_START_TMO  = 16'd5000;
  localparam logic [WTO_W-1:0]   RST_WIDTH_TMO  = 17'd60000;
  localparam logic [SAFE_W-1:0]  RST_SAFE_WIDTH = 17'd1000;
  localparam logic [GAP_W-1:0]   RST_BURST_GAP  = 20'd100000;

  // Phase of the ranging cycle.
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_TRIG  = 3'd1,
    PH_RISE  = 3'd2,
    PH_MEAS  = 3'd3,
    PH_GAP   = 3'd4
  } phase_t;

  // Datapath operation selected by a control word.
  typedef enum logic [2:0] {
    OP_NOP      = 3'd0,
    OP_FETCH    = 3'd1,
    OP_TICK     = 3'd2,
    OP_DIV_INIT = 3'd3,
    OP_DIV_STEP = 3'd4,
    OP_AVG      = 3'd5,
    OP_EMIT     = 3'd6
  } dp_op_t;

  // Jump condition of a control word.
  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_ALWAYS   = 3'd1,
    C_NO_INPUT = 3'd2,
    C_NO_AVG   = 3'd3,
    C_DIV_MORE = 3'd4,
    C_OUT_BUSY = 3'd5
  } cond_t;

  typedef logic [2:0] step_t;

  // Program addresses.
  localparam step_t STEP_FETCH    = 3'd0;
  localparam step_t STEP_TICK     = 3'd1;
  localparam step_t STEP_DIV_INIT = 3'd2;
  localparam step_t STEP_DIV_STEP = 3'd3;
  localparam step_t STEP_AVG      = 3'd4;
  localparam step_t STEP_EMIT     = 3'd5;
  localparam step_t STEP_WRAP     = 3'd6;

  // One control word: operation, jump condition and jump target.
  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    step_t  target;
  } ucode_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic in_fire;
    logic avg_due;
    logic div_more;
    logic out_busy;
  } flags_t;

  // Control store. A taken jump goes to target, otherwise to the next step.
  function automatic ucode_t ucode_rom(input step_t addr);
    ucode_t w;
    unique case (addr)
      STEP_FETCH:    w = '{op: OP_FETCH,    cond: C_NO_INPUT, target: STEP_FETCH};
      STEP_TICK:     w = '{op: OP_TICK,     cond: C_NO_AVG,   target: STEP_EMIT};
      STEP_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_NEVER,    target: STEP_FETCH};
      STEP_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE, target: STEP_DIV_STEP};
      STEP_AVG:      w = '{op: OP_AVG,      cond: C_NEVER,    target: STEP_FETCH};
      STEP_EMIT:     w = '{op: OP_EMIT,     cond: C_OUT_BUSY, target: STEP_EMIT};
      STEP_WRAP:     w = '{op: OP_NOP,      cond: C_ALWAYS,   target: STEP_FETCH};
      default:       w = '{op: OP_NOP,      cond: C_ALWAYS,   target: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> sv/sbr_seq.sv
// Microcode sequencer: step counter, control store read and conditional jumps.
`default_nettype none

module sbr_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sbr_pkg::flags_t flags,
  output sbr_pkg::ucode_t      ctl
);

  sbr_pkg::step_t pc;
  sbr_pkg::step_t pc_next;
  logic           take;

  // The current control word comes straight from the store.
  assign ctl = sbr_pkg::ucode_rom(pc);

  // Evaluate the jump condition and pick the next step.
  always_comb begin
    unique case (ctl.cond)
      sbr_pkg::C_NEVER:    take = 1'b0;
      sbr_pkg::C_ALWAYS:   take = 1'b1;
      sbr_pkg::C_NO_INPUT: take = !flags.in_fire;
      sbr_pkg::C_NO_AVG:   take = !flags.avg_due;
      sbr_pkg::C_DIV_MORE: take = flags.div_more;
      sbr_pkg::C_OUT_BUSY: take = flags.out_busy;
      default:             take = 1'b0;
    endcase
    pc_next = take ? ctl.target : pc + 1'b1;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= sbr_pkg::STEP_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/sonar_burst_ranger_core.sv
// Sonar burst ranger top level: configuration, ranging datapath and output register.
//
// Each input transfer is one microsecond tick carrying the sampled echo level;
// every input transfer yields exactly one output transfer with the trigger
// level, the danger LED, the held average width and the burst flags.
// Both channels use valid and stall; a transfer happens on an edge with valid
// high and stall low. Registers are written through cfg_we, cfg_index and
// cfg_wdata, one per edge; the user must write them only while the block is
// idle, which the block itself does not enforce. A microcode sequencer runs
// each tick: fetch, phase update, then output. An ordinary tick runs the fetch,
// tick, emit and wrap steps before the next input transfer; the tick step
// registers its result, which enters the output register in the emit step.
// A tick that closes a burst with valid readings also runs the averaging
// divide, one quotient bit per cycle, and stores the average before emit.
// The result sits in an output register, so the next tick is accepted while
// it waits; a stalled receiver holds the block only once a second result is
// ready. Reset restores the register defaults, clears the held average and
// the LED, and starts a burst on the first tick.
`default_nettype none

module sonar_burst_ranger_core #(
  parameter int MAX_READINGS = sbr_pkg::MAX_READINGS_DEF,
  parameter int WIDTH_BITS   = sbr_pkg::WIDTH_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Configuration write port.
  input  wire logic                            cfg_we,
  input  wire logic [sbr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sbr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Input channel.
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            echo_level,
  // Output channel.
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 trigger_level,
  output logic                                 led_on,
  output logic [WIDTH_BITS-1:0]                average_width,
  output logic                                 burst_done,
  output logic                                 burst_valid
);

  localparam int CNT_BITS  = $clog2(MAX_READINGS + 1);
  localparam int SUM_BITS  = WIDTH_BITS + $clog2(MAX_READINGS);
  localparam int TICK_BITS = (WIDTH_BITS + 1 > sbr_pkg::GAP_W) ? WIDTH_BITS + 1
                                                                : sbr_pkg::GAP_W;
  localparam int LIM_W     = (WIDTH_BITS > sbr_pkg::WTO_W) ? WIDTH_BITS : sbr_pkg::WTO_W;
  localparam int CMP_W     = (CNT_BITS > sbr_pkg::RPB_W) ? CNT_BITS : sbr_pkg::RPB_W;
  localparam int DCNT_W    = $clog2(SUM_BITS + 1);
  localparam logic [LIM_W-1:0] WIDTH_MAX = LIM_W'((64'd1 << WIDTH_BITS) - 64'd1);
  localparam logic [CMP_W-1:0] MAX_LEN   = CMP_W'(MAX_READINGS);

  // Configuration registers.
  logic [sbr_pkg::RPB_W-1:0]   readings_per_burst;
  logic [sbr_pkg::TRIG_W-1:0]  trigger_width_us;
  logic [sbr_pkg::START_W-1:0] start_timeout_us;
  logic [sbr_pkg::WTO_W-1:0]   width_timeout_us;
  logic [sbr_pkg::SAFE_W-1:0]  safe_width_us;
  logic [sbr_pkg::GAP_W-1:0]   burst_gap_us;

  // Ranging state.
  sbr_pkg::phase_t       phase;
  logic [TICK_BITS-1:0]  phase_ticks;
  logic [CNT_BITS-1:0]   reading_index;
  logic [CNT_BITS-1:0]   valid_count;
  logic [SUM_BITS-1:0]   width_sum;
  logic [WIDTH_BITS-1:0] average_hold;
  logic                  led_hold;

  // Per-tick working registers.
  logic                  echo_r;
  logic                  res_trig;
  logic                  res_done;
  logic                  res_valid;

  // Divider registers: remainder, shifting dividend and quotient, step count.
  logic [CNT_BITS-1:0]   div_rem;
  logic [SUM_BITS-1:0]   div_quo;
  logic [DCNT_W-1:0]     div_cnt;

  // Sequencer interface.
  sbr_pkg::ucode_t       ctl;
  sbr_pkg::flags_t       flags;
  logic                  in_fire;
  logic                  out_busy;

  // Next values of the phase update.
  sbr_pkg::phase_t       phase_next;
  logic [TICK_BITS-1:0]  phase_ticks_next;
  logic [CNT_BITS-1:0]   reading_index_next;
  logic [CNT_BITS-1:0]   valid_count_next;
  logic [SUM_BITS-1:0]   width_sum_next;
  logic                  trig_next;
  logic                  finished;
  logic                  end_rd;

  // Limits derived from the registers.
  logic [sbr_pkg::TRIG_W-1:0]  trig1;
  logic [sbr_pkg::START_W-1:0] start1;
  logic [sbr_pkg::WTO_W-1:0]   wto1;
  logic [LIM_W-1:0]            wlim;
  logic [CMP_W-1:0]            rpb1;
  logic [CMP_W-1:0]            blen;

  // Divider step.
  logic [CNT_BITS:0]     div_trial;
  logic                  div_ge;
  logic [CNT_BITS:0]     div_diff;

  sbr_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  // Handshake and sequencer flags.
  assign in_stall = (ctl.op != sbr_pkg::OP_FETCH);
  assign in_fire  = in_valid && !in_stall;
  assign out_busy = out_valid && out_stall;

  assign flags.in_fire  = in_fire;
  assign flags.avg_due  = finished && (valid_count_next != '0);
  assign flags.div_more = (div_cnt != DCNT_W'(1));
  assign flags.out_busy = out_busy;

  // A zero setting acts as one; the burst length and width limit are clamped.
  always_comb begin
    trig1  = (trigger_width_us == '0) ? sbr_pkg::TRIG_W'(1) : trigger_width_us;
    start1 = (start_timeout_us == '0) ? sbr_pkg::START_W'(1) : start_timeout_us;
    wto1   = (width_timeout_us == '0) ? sbr_pkg::WTO_W'(1) : width_timeout_us;
    wlim   = (LIM_W'(wto1) > WIDTH_MAX) ? WIDTH_MAX : LIM_W'(wto1);
    rpb1   = (readings_per_burst == '0) ? CMP_W'(1) : CMP_W'(readings_per_burst);
    blen   = (rpb1 > MAX_LEN) ? MAX_LEN : rpb1;
  end

  // Phase update for one tick.
  always_comb begin
    phase_next         = phase;
    phase_ticks_next   = phase_ticks;
    reading_index_next = reading_index;
    valid_count_next   = valid_count;
    width_sum_next     = width_sum;
    trig_next          = 1'b0;
    end_rd             = 1'b0;
    finished           = 1'b0;
    unique case (phase) inside
      sbr_pkg::PH_START, sbr_pkg::PH_TRIG: begin
        // The start tick clears the burst and is also the first trigger tick.
        if (phase == sbr_pkg::PH_START) begin
          reading_index_next = '0;
          valid_count_next   = '0;
          width_sum_next     = '0;
          phase_ticks_next   = '0;
        end
        trig_next        = 1'b1;
        phase_ticks_next = phase_ticks_next + 1'b1;
        if (phase_ticks_next >= TICK_BITS'(trig1)) begin
          phase_next       = sbr_pkg::PH_RISE;
          phase_ticks_next = '0;
        end else begin
          phase_next = sbr_pkg::PH_TRIG;
        end
      end
      sbr_pkg::PH_RISE: begin
        if (echo_r) begin
          phase_next       = sbr_pkg::PH_MEAS;
          phase_ticks_next = TICK_BITS'(1);
        end else begin
          phase_ticks_next = phase_ticks + 1'b1;
          end_rd = (phase_ticks_next >= TICK_BITS'(start1));
        end
      end
      sbr_pkg::PH_MEAS: begin
        if (!echo_r) begin
          width_sum_next   = width_sum + SUM_BITS'(phase_ticks);
          valid_count_next = valid_count + 1'b1;
          end_rd           = 1'b1;
        end else begin
          phase_ticks_next = phase_ticks + 1'b1;
          end_rd = (phase_ticks_next > TICK_BITS'(wlim));
        end
      end
      default: begin
        // Gap between bursts; unused codes behave the same.
        phase_ticks_next = phase_ticks + 1'b1;
        if (phase_ticks_next >= TICK_BITS'(burst_gap_us)) begin
          phase_next       = sbr_pkg::PH_START;
          phase_ticks_next = '0;
        end
      end
    endcase

    // End of a reading: next trigger, or close the burst.
    if (end_rd) begin
      reading_index_next = reading_index_next + 1'b1;
      phase_ticks_next   = '0;
      if (CMP_W'(reading_index_next) >= blen) begin
        finished   = 1'b1;
        phase_next = (burst_gap_us == '0) ? sbr_pkg::PH_START : sbr_pkg::PH_GAP;
      end else begin
        phase_next = sbr_pkg::PH_TRIG;
      end
    end
  end

  // Restoring divide step: one quotient bit per cycle.
  always_comb begin
    div_trial = {div_rem, div_quo[SUM_BITS-1]};
    div_ge    = (div_trial >= {1'b0, valid_count});
    div_diff  = div_trial - {1'b0, valid_count};
  end

  // Control state: configuration, ranging state, held results, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      readings_per_burst <= sbr_pkg::RST_READINGS;
      trigger_width_us   <= sbr_pkg::RST_TRIG_WIDTH;
      start_timeout_us   <= sbr_pkg::RST_START_TMO;
      width_timeout_us   <= sbr_pkg::RST_WIDTH_TMO;
      safe_width_us      <= sbr_pkg::RST_SAFE_WIDTH;
      burst_gap_us       <= sbr_pkg::RST_BURST_GAP;
      phase              <= sbr_pkg::PH_START;
      phase_ticks        <= '0;
      reading_index      <= '0;
      valid_count        <= '0;
      width_sum          <= '0;
      average_hold       <= '0;
      led_hold           <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sbr_pkg::REG_READINGS:   readings_per_burst <= cfg_wdata[sbr_pkg::RPB_W-1:0];
          sbr_pkg::REG_TRIG_WIDTH: trigger_width_us   <= cfg_wdata[sbr_pkg::TRIG_W-1:0];
          sbr_pkg::REG_START_TMO:  start_timeout_us   <= cfg_wdata[sbr_pkg::START_W-1:0];
          sbr_pkg::REG_WIDTH_TMO:  width_timeout_us   <= cfg_wdata[sbr_pkg::WTO_W-1:0];
          sbr_pkg::REG_SAFE_WIDTH: safe_width_us      <= cfg_wdata[sbr_pkg::SAFE_W-1:0];
          sbr_pkg::REG_BURST_GAP:  burst_gap_us       <= cfg_wdata[sbr_pkg::GAP_W-1:0];
          default: ;
        endcase
      end
      if (ctl.op == sbr_pkg::OP_TICK) begin
        phase         <= phase_next;
        phase_ticks   <= phase_ticks_next;
        reading_index <= reading_index_next;
        valid_count   <= valid_count_next;
        width_sum     <= width_sum_next;
      end
      if (ctl.op == sbr_pkg::OP_AVG) begin
        average_hold <= div_quo[WIDTH_BITS-1:0];
        led_hold     <= (LIM_W'(div_quo[WIDTH_BITS-1:0]) < LIM_W'(safe_width_us));
      end
      // The output register empties on a transfer and refills on emit.
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if ((ctl.op == sbr_pkg::OP_EMIT) && !out_busy) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Payload registers: sampled echo, tick results, divider, output fields.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      echo_r <= echo_level;
    end
    if (ctl.op == sbr_pkg::OP_TICK) begin
      res_trig  <= trig_next;
      res_done  <= finished;
      res_valid <= flags.avg_due;
    end
    if (ctl.op == sbr_pkg::OP_DIV_INIT) begin
      div_rem <= '0;
      div_quo <= width_sum;
      div_cnt <= DCNT_W'(SUM_BITS);
    end
    if (ctl.op == sbr_pkg::OP_DIV_STEP) begin
      div_rem <= div_ge ? div_diff[CNT_BITS-1:0] : div_trial[CNT_BITS-1:0];
      div_quo <= {div_quo[SUM_BITS-2:0], div_ge};
      div_cnt <= div_cnt - 1'b1;
    end
    if ((ctl.op == sbr_pkg::OP_EMIT) && !out_busy) begin
      trigger_level <= res_trig;
      burst_done    <= res_done;
      burst_valid   <= res_valid;
      led_on        <= led_hold;
      average_width <= average_hold;
    end
  end

endmodule

`default_nettype wire

>>> sv/sbr_checker.sv
// Port-level checker for the sonar burst ranger, bound to the top level.
`default_nettype none

module sbr_checker #(
  parameter int WIDTH_BITS = sbr_pkg::WIDTH_BITS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic                  trigger_level,
  input wire logic                  led_on,
  input wire logic [WIDTH_BITS-1:0] average_width,
  input wire logic                  burst_done,
  input wire logic                  burst_valid
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A valid burst flag only comes with burst completion.
  a_valid_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && burst_valid |-> burst_done)
    else $error("burst_valid without burst_done");

  // A trigger tick never closes a burst.
  a_trig_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && trigger_level |-> !burst_done)
    else $error("burst completed on a trigger tick");

  // A tick runs further steps after the fetch, so an input transfer is followed by a stall.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(trigger_level) && $stable(led_on)
      && $stable(average_width) && $stable(burst_done) && $stable(burst_valid))
    else $error("stalled result changed");

endmodule

bind sonar_burst_ranger_core sbr_checker #(.WIDTH_BITS(WIDTH_BITS)) u_sbr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .trigger_level (trigger_level),
  .led_on        (led_on),
  .average_width (average_width),
  .burst_done    (burst_done),
  .burst_valid   (burst_valid)
);

`default_nettype wire
